### sv/wsi_pkg.sv
// Shared types, field widths and codes for the workout setpoint interpolator.
package wsi_pkg;

	localparam int TIME_W = 32;
	localparam int VAL_W  = 24;
	localparam int POW_W  = 16;
	localparam int LAPN_W = 7;

	// Input item: mode in tuser, time and point value in tdata.
	localparam int S_DATA_W = 56;
	// Result item: status in tuser, all other fields in tdata.
	localparam int M_DATA_W = 120;

	// Interpolation arithmetic: value times a time span, and its magnitude.
	localparam int PROD_W = VAL_W + TIME_W + 1;
	localparam int NUM_W  = VAL_W + TIME_W;
	localparam int QUO_W  = VAL_W;

	// Power and gradient reported on a failed query, in whole units.
	localparam int ERR_VALUE = -100;

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_POINT,
		MODE_LAP,
		MODE_QUERY
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NO_PROFILE,
		STAT_RANGE,
		STAT_FULL
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [POW_W-1:0]    power;
		logic [VAL_W-1:0]    gradient;
		logic [LAPN_W-1:0]   lap_number;
		logic [TIME_W-1:0]   next_lap_start;
		logic                next_lap_found;
		logic [TIME_W-1:0]   current_lap_start;
		logic                current_lap_found;
	} res_t;

endpackage

### sv/wsi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/wsi_divider.sv
// Restoring bit-serial divider: unsigned dividend magnitude by a time span.
module wsi_divider import wsi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] div_q;
	logic [NUM_W-1:0]  num_q;
	logic [TIME_W:0]   shifted;
	logic [TIME_W:0]   diff;
	logic              fits;

	// One quotient bit per cycle; the dividend register fills with quotient bits.
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = !diff[TIME_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q[QUO_W-1:0];

endmodule

### sv/workout_setpoint_interpolator.sv
// Top level of the workout setpoint interpolator: profile and lap tables with queries.
//
// Items enter on the s_axis channel: s_axis_tuser carries the mode (clear, append
// point, append lap, query) and s_axis_tdata carries the time in ms (bits 31:0) and
// the signed point value (bits 55:32). Every item gives exactly one result item on
// the m_axis channel: m_axis_tuser carries the status, m_axis_tdata the power,
// gradient, lap count and the next and current lap starts.
// Clear and append items finish in the cycle they are accepted; their result goes
// to the holding register and then to the output register. A query scans the lap
// table at one entry a cycle, walks the segment cursor one step at a time through a
// read state and a compare state, fetches the segment through the SEG_L, SEG_R and
// SEG_W states, and then divides one quotient bit a cycle in the serial divider.
// The single read port of each table RAM and the serial divider set this sequencing.
// One item is in work at a time. A finished result waits in a holding register
// while the output register is stalled, so the next item is taken as soon as the
// holding register is empty. Reset empties both tables and the cursor at once;
// table contents are not cleared and are only read below the fill counts.
module workout_setpoint_interpolator import wsi_pkg::*; #(
	parameter int MAX_POINTS      = 256,
	parameter int MAX_LAPS        = 64,
	parameter int VALUE_FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// time_ms [31:0], point_value [55:32]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// mode [1:0]
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// power [15:0], gradient [39:16], lap_number [46:40], next_lap_start [78:47],
	// next_lap_found [79], current_lap_start [111:80], current_lap_found [112], zeros
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [1:0]          m_axis_tuser
);

	localparam int PA_W = $clog2(MAX_POINTS);
	localparam int PC_W = $clog2(MAX_POINTS + 1);
	localparam int LA_W = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
	localparam int LC_W = $clog2(MAX_LAPS + 1);
	localparam int PT_W = TIME_W + VAL_W;

	localparam logic [POW_W-1:0] ERR_POWER = POW_W'(ERR_VALUE);
	localparam logic [VAL_W-1:0] ERR_GRAD  = VAL_W'(ERR_VALUE * (2 ** VALUE_FRAC_BITS));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAP,
		ST_BACK_RD,
		ST_BACK_CMP,
		ST_FWD_RD,
		ST_FWD_CMP,
		ST_SEG_L,
		ST_SEG_R,
		ST_SEG_W,
		ST_MUL,
		ST_SUM,
		ST_DIVS,
		ST_DIVW,
		ST_OUT
	} state_t;

	state_t state_q;

	// Input fields.
	mode_t                    in_mode;
	logic [TIME_W-1:0]        in_time;
	logic signed [VAL_W-1:0]  in_value;
	logic                     in_fire;

	assign in_mode  = mode_t'(s_axis_tuser);
	assign in_time  = s_axis_tdata[TIME_W-1:0];
	assign in_value = s_axis_tdata[PT_W-1:TIME_W];

	// Table bookkeeping.
	logic [PC_W-1:0]   pt_cnt_q;
	logic [LC_W-1:0]   lap_cnt_q;
	logic [PA_W-1:0]   cursor_q;
	logic [TIME_W-1:0] first_time_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] last_lap_q;

	// Query work registers.
	logic [TIME_W-1:0] t_q;
	logic [PA_W-1:0]   seg_c_q;
	logic [LC_W-1:0]   lap_rd_q;
	logic              lap_dv_s1;
	logic              lap_pv_q;
	logic [TIME_W-1:0] lap_prev_q;
	logic [LC_W-1:0]   lapn_q;
	logic [TIME_W-1:0] nls_q;
	logic              nf_q;
	logic [TIME_W-1:0] cls_q;
	logic              cf_q;

	logic [TIME_W-1:0]       tl_q;
	logic [TIME_W-1:0]       tr_q;
	logic signed [VAL_W-1:0] vl_q;
	logic signed [VAL_W-1:0] vr_q;
	logic signed [PROD_W-1:0] prod_l_q;
	logic signed [PROD_W-1:0] prod_r_q;
	logic signed [PROD_W-1:0] num_q;
	logic [TIME_W-1:0]       dt_q;
	logic                    flat_q;
	logic                    neg_q;
	logic [QUO_W-1:0]        mag_q;

	// Holding register between the sequencer and the output register.
	res_t res_q;
	logic res_pend_q;
	res_t out_q;
	logic out_valid_q;
	logic res_move;

	assign res_move      = res_pend_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE) && !res_pend_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Memories: points hold {value, time}; laps hold start times.
	logic              pt_we;
	logic [PA_W-1:0]   pt_raddr;
	logic [PT_W-1:0]   pt_rdata;
	logic              lap_we;
	logic [TIME_W-1:0] lap_rdata;
	logic [TIME_W-1:0] pt_rtime;
	logic [VAL_W-1:0]  pt_rvalue;

	assign pt_rtime  = pt_rdata[TIME_W-1:0];
	assign pt_rvalue = pt_rdata[PT_W-1:TIME_W];

	assign pt_we  = in_fire && (in_mode == MODE_POINT) && (pt_cnt_q < PC_W'(MAX_POINTS))
		&& !((pt_cnt_q != '0) && (in_time < last_time_q));
	assign lap_we = in_fire && (in_mode == MODE_LAP) && (lap_cnt_q < LC_W'(MAX_LAPS))
		&& !((lap_cnt_q != '0) && (in_time < last_lap_q));

	always_comb begin
		pt_raddr = seg_c_q;
		case (state_q)
			ST_FWD_RD, ST_SEG_R: pt_raddr = seg_c_q + PA_W'(1);
			default:             pt_raddr = seg_c_q;
		endcase
	end

	wsi_ram #(
		.WIDTH(PT_W),
		.DEPTH(MAX_POINTS)
	) u_pt_ram (
		.clk  (clk),
		.we   (pt_we),
		.waddr(pt_cnt_q[PA_W-1:0]),
		.wdata({in_value, in_time}),
		.raddr(pt_raddr),
		.rdata(pt_rdata)
	);

	wsi_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_LAPS)
	) u_lap_ram (
		.clk  (clk),
		.we   (lap_we),
		.waddr(lap_cnt_q[LA_W-1:0]),
		.wdata(in_time),
		.raddr(lap_rd_q[LA_W-1:0]),
		.rdata(lap_rdata)
	);

	// Interpolation datapath: the two weighted products, then the divider.
	logic signed [PROD_W-1:0] prod_l;
	logic signed [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0]        num_abs;
	logic [QUO_W-1:0]         vr_abs;
	logic                     div_start;
	logic                     div_done;
	logic [QUO_W-1:0]         div_quo;
	logic [QUO_W-1:0]         mag_sh;
	logic [QUO_W-1:0]         pw_full;

	assign prod_l  = $signed(vl_q) * $signed({1'b0, tr_q - t_q});
	assign prod_r  = $signed(vr_q) * $signed({1'b0, t_q - tl_q});
	assign num_abs = num_q[PROD_W-1] ? (PROD_W'(0) - num_q) : num_q;
	assign vr_abs  = vr_q[VAL_W-1] ? (QUO_W'(0) - vr_q) : vr_q;
	assign div_start = (state_q == ST_DIVS) && !flat_q;
	assign mag_sh  = mag_q >> VALUE_FRAC_BITS;
	assign pw_full = neg_q ? (QUO_W'(0) - mag_sh) : mag_sh;

	wsi_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num_abs[NUM_W-1:0]),
		.divisor (dt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Segment cursor limit for the walk: the last segment starts at count minus two.
	logic [PC_W-1:0] pt_cnt_m2;
	logic [PA_W-1:0] cursor_clamp;
	logic            out_of_range;

	assign pt_cnt_m2    = pt_cnt_q - PC_W'(2);
	assign cursor_clamp = (PC_W'(cursor_q) > pt_cnt_m2) ? pt_cnt_m2[PA_W-1:0] : cursor_q;
	assign out_of_range = (t_q < first_time_q) || (t_q > last_time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_pend_q   <= 1'b0;
			pt_cnt_q     <= '0;
			lap_cnt_q    <= '0;
			cursor_q     <= '0;
			first_time_q <= '0;
			last_time_q  <= '0;
			last_lap_q   <= '0;
			t_q          <= '0;
			seg_c_q      <= '0;
			lap_rd_q     <= '0;
			lap_dv_s1    <= 1'b0;
			lap_pv_q     <= 1'b0;
			lap_prev_q   <= '0;
			lapn_q       <= '0;
			nls_q        <= '0;
			nf_q         <= 1'b0;
			cls_q        <= '0;
			cf_q         <= 1'b0;
			tl_q         <= '0;
			tr_q         <= '0;
			vl_q         <= '0;
			vr_q         <= '0;
			prod_l_q     <= '0;
			prod_r_q     <= '0;
			num_q        <= '0;
			dt_q         <= '0;
			flat_q       <= 1'b0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			res_q        <= '0;
		end else begin
			if (res_move) begin
				res_pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_q      <= '0;
						res_pend_q <= 1'b1;
						t_q        <= in_time;
						unique case (in_mode)
							MODE_CLEAR: begin
								pt_cnt_q     <= '0;
								lap_cnt_q    <= '0;
								cursor_q     <= '0;
								res_q.status <= STAT_OK;
							end
							MODE_POINT: begin
								if (pt_cnt_q >= PC_W'(MAX_POINTS)) begin
									res_q.status <= STAT_FULL;
								end else if (!pt_we) begin
									res_q.status <= STAT_RANGE;
								end else begin
									if (pt_cnt_q == '0) begin
										first_time_q <= in_time;
									end
									last_time_q  <= in_time;
									pt_cnt_q     <= pt_cnt_q + PC_W'(1);
									res_q.status <= STAT_OK;
								end
							end
							MODE_LAP: begin
								if (lap_cnt_q >= LC_W'(MAX_LAPS)) begin
									res_q.status <= STAT_FULL;
								end else if (!lap_we) begin
									res_q.status <= STAT_RANGE;
								end else begin
									last_lap_q   <= in_time;
									lap_cnt_q    <= lap_cnt_q + LC_W'(1);
									res_q.status <= STAT_OK;
								end
							end
							MODE_QUERY: begin
								if (pt_cnt_q < PC_W'(2)) begin
									res_q.status   <= STAT_NO_PROFILE;
									res_q.power    <= ERR_POWER;
									res_q.gradient <= ERR_GRAD;
								end else begin
									// The result comes later; the holding register stays empty.
									res_pend_q <= 1'b0;
									lap_rd_q   <= '0;
									lap_dv_s1  <= 1'b0;
									lap_pv_q   <= 1'b0;
									lapn_q     <= '0;
									nf_q       <= 1'b0;
									cf_q       <= 1'b0;
									nls_q      <= '0;
									cls_q      <= '0;
									state_q    <= ST_LAP;
								end
							end
						endcase
					end
				end
				ST_LAP: begin
					// Lap reads are pipelined: one issued and one checked per cycle.
					if (lap_dv_s1) begin
						if (t_q >= lap_rdata) begin
							lapn_q <= lapn_q + LC_W'(1);
						end else begin
							if (!nf_q) begin
								nls_q <= lap_rdata;
								nf_q  <= 1'b1;
							end
							if (!cf_q && lap_pv_q) begin
								cls_q <= lap_prev_q;
								cf_q  <= 1'b1;
							end
						end
						lap_prev_q <= lap_rdata;
						lap_pv_q   <= 1'b1;
					end
					if (lap_rd_q < lap_cnt_q) begin
						lap_rd_q  <= lap_rd_q + LC_W'(1);
						lap_dv_s1 <= 1'b1;
					end else begin
						lap_dv_s1 <= 1'b0;
						if (!lap_dv_s1) begin
							if (out_of_range) begin
								res_q.status            <= STAT_RANGE;
								res_q.power             <= ERR_POWER;
								res_q.gradient          <= ERR_GRAD;
								res_q.lap_number        <= '0;
								res_q.next_lap_start    <= nls_q;
								res_q.next_lap_found    <= nf_q;
								res_q.current_lap_start <= cls_q;
								res_q.current_lap_found <= cf_q;
								res_pend_q              <= 1'b1;
								state_q                 <= ST_IDLE;
							end else begin
								seg_c_q <= cursor_clamp;
								state_q <= ST_BACK_RD;
							end
						end
					end
				end
				ST_BACK_RD: begin
					state_q <= (seg_c_q == '0) ? ST_FWD_RD : ST_BACK_CMP;
				end
				ST_BACK_CMP: begin
					if (t_q < pt_rtime) begin
						seg_c_q <= seg_c_q - PA_W'(1);
						state_q <= ST_BACK_RD;
					end else begin
						state_q <= ST_FWD_RD;
					end
				end
				ST_FWD_RD: begin
					state_q <= ((PC_W'(seg_c_q) + PC_W'(2)) < pt_cnt_q) ? ST_FWD_CMP : ST_SEG_L;
				end
				ST_FWD_CMP: begin
					if (t_q > pt_rtime) begin
						seg_c_q <= seg_c_q + PA_W'(1);
						state_q <= ST_FWD_RD;
					end else begin
						state_q <= ST_SEG_L;
					end
				end
				ST_SEG_L: begin
					state_q <= ST_SEG_R;
				end
				ST_SEG_R: begin
					tl_q    <= pt_rtime;
					vl_q    <= pt_rvalue;
					state_q <= ST_SEG_W;
				end
				ST_SEG_W: begin
					tr_q     <= pt_rtime;
					vr_q     <= pt_rvalue;
					cursor_q <= seg_c_q;
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					prod_l_q <= prod_l;
					prod_r_q <= prod_r;
					dt_q     <= tr_q - tl_q;
					flat_q   <= (vl_q == vr_q) || (tl_q == tr_q);
					state_q  <= ST_SUM;
				end
				ST_SUM: begin
					num_q   <= prod_l_q + prod_r_q;
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					// A flat or zero-length segment gives the right-hand value directly.
					if (flat_q) begin
						mag_q   <= vr_abs;
						neg_q   <= vr_q[VAL_W-1];
						state_q <= ST_OUT;
					end else begin
						neg_q   <= num_q[PROD_W-1];
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						mag_q   <= div_quo;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					res_q.status            <= STAT_OK;
					res_q.power             <= pw_full[POW_W-1:0];
					res_q.gradient          <= vl_q;
					res_q.lap_number        <= LAPN_W'(lapn_q);
					res_q.next_lap_start    <= nls_q;
					res_q.next_lap_found    <= nf_q;
					res_q.current_lap_start <= cls_q;
					res_q.current_lap_found <= cf_q;
					res_pend_q              <= 1'b1;
					state_q                 <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register; it reloads from the holding register when taken or empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_move) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {7'd0, out_q.current_lap_found, out_q.current_lap_start,
		out_q.next_lap_found, out_q.next_lap_start, out_q.lap_number,
		out_q.gradient, out_q.power};

`ifndef SYNTHESIS
	a_pt_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pt_cnt_q <= PC_W'(MAX_POINTS))
		else $error("point count beyond table depth");

	a_seg_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ((PC_W'(seg_c_q) + PC_W'(2)) <= pt_cnt_q))
		else $error("segment cursor outside the profile");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVW))
		else $error("divider finished outside its wait state");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_mode == MODE_QUERY) && (pt_cnt_q >= PC_W'(2)))
		|=> (!s_axis_tready && !res_pend_q))
		else $error("query did not hold off the input");
`endif

endmodule
